// ===== design/sqtg_pkg.sv =====
package sqtg_pkg;

    localparam int unsigned TIMEBASE_HZ_DEFAULT = 1000000;

    localparam int OP_W    = 2;
    localparam int PIN_W   = 8;
    localparam int FREQ_W  = 16;
    localparam int DUR_W   = 32;
    localparam int HALF_W  = 16;
    localparam int BUDGET_W = 23;

    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 16;

    localparam int DIV_W     = 32;
    localparam int DIV_STEPS = DIV_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_PLAY = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP = 2'd2;

    localparam logic [PIN_W-1:0]  NO_OWNER       = 8'hFF;

    // Division of a 32-bit value by 1000 as a multiply by ceil(2^38 / 1000) and a shift by 38.
    localparam logic [31:0] BUDGET_RECIP = 32'd274877907;
    localparam int          BUDGET_SHIFT = 38;

    typedef struct packed {
        logic apply_now;
        logic start_play;
        logic mul_load;
        logic div_load_tb;
        logic budget_load;
        logic div_step;
        logic save_half;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic play_refused;
        logic out_free;
    } status_t;

endpackage

// ===== design/sqtg_datapath.sv =====
module sqtg_datapath #(
    parameter int unsigned TIMEBASE_HZ = sqtg_pkg::TIMEBASE_HZ_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sqtg_pkg::cmd_t                cmd,
    output sqtg_pkg::status_t             status,
    input  logic [sqtg_pkg::OP_W-1:0]     op,
    input  logic [sqtg_pkg::S_DATA_W-1:0] in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sqtg_pkg::M_DATA_W-1:0] out_data
);

    logic [sqtg_pkg::PIN_W-1:0]    pin_in;
    logic [sqtg_pkg::FREQ_W-1:0]   freq_in;
    logic [sqtg_pkg::DUR_W-1:0]    dur_in;

    logic [sqtg_pkg::PIN_W-1:0]    pin_reg;
    logic [sqtg_pkg::FREQ_W-1:0]   freq_reg;
    logic [sqtg_pkg::DUR_W-1:0]    dur_reg;
    logic [sqtg_pkg::DIV_W-1:0]    prod_reg;
    logic [sqtg_pkg::HALF_W-1:0]   half_tmp_reg;
    logic [sqtg_pkg::BUDGET_W-1:0] budget_reg;

    logic [sqtg_pkg::DIV_W-1:0]    div_num_reg;
    logic [sqtg_pkg::DIV_W-1:0]    div_num_next;
    logic [sqtg_pkg::FREQ_W-1:0]   div_den_reg;
    logic [sqtg_pkg::FREQ_W-1:0]   div_rem_reg;
    logic [sqtg_pkg::FREQ_W-1:0]   div_rem_next;
    logic [sqtg_pkg::FREQ_W:0]     rem_shift;
    logic                          rem_ge;

    logic [47:0]                   mul_full;
    logic [63:0]                   budget_full;

    logic [sqtg_pkg::PIN_W-1:0]    owner_reg, owner_next;
    logic [sqtg_pkg::HALF_W-1:0]   half_period_reg, half_period_next;
    logic [sqtg_pkg::HALF_W-1:0]   tick_count_reg, tick_count_next;
    logic [sqtg_pkg::BUDGET_W-1:0] toggles_left_reg, toggles_left_next;
    logic                          endless_reg, endless_next;
    logic                          enabled_reg, enabled_next;
    logic                          level_reg, level_next;
    logic                          refused_next;

    logic [sqtg_pkg::HALF_W-1:0]   limit;
    logic [sqtg_pkg::HALF_W-1:0]   tick_inc;

    logic                          out_valid_reg;
    logic [sqtg_pkg::M_DATA_W-1:0] out_data_reg;
    logic                          out_load;

    assign pin_in  = in_data[7:0];
    assign freq_in = in_data[23:8];
    assign dur_in  = in_data[55:24];

    assign status.play_refused = (owner_reg != pin_in) && (owner_reg != sqtg_pkg::NO_OWNER);
    assign status.out_free     = !out_valid_reg || out_ready;

    assign mul_full    = 48'(freq_reg) * 48'(dur_reg);
    assign budget_full = 64'(prod_reg) * 64'(sqtg_pkg::BUDGET_RECIP);

    assign rem_shift    = {div_rem_reg, div_num_reg[sqtg_pkg::DIV_W-1]};
    assign rem_ge       = rem_shift >= {1'b0, div_den_reg};
    assign div_rem_next = rem_ge ? 16'(rem_shift - {1'b0, div_den_reg}) : rem_shift[15:0];
    assign div_num_next = {div_num_reg[sqtg_pkg::DIV_W-2:0], rem_ge};

    always_ff @(posedge clk)
    begin
        if (cmd.start_play)
        begin
            pin_reg  <= pin_in;
            freq_reg <= freq_in;
            dur_reg  <= dur_in;
        end
        if (cmd.mul_load)
        begin
            prod_reg <= {mul_full[30:0], 1'b0};
        end
        if (cmd.div_load_tb)
        begin
            div_num_reg <= sqtg_pkg::DIV_W'(TIMEBASE_HZ);
            div_den_reg <= freq_reg;
            div_rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_num_reg <= div_num_next;
            div_rem_reg <= div_rem_next;
        end
        if (cmd.save_half)
        begin
            half_tmp_reg <= (freq_reg == '0) ? 16'hFFFF : div_num_reg[16:1];
        end
        if (cmd.budget_load)
        begin
            budget_reg <= budget_full[sqtg_pkg::BUDGET_SHIFT +: sqtg_pkg::BUDGET_W];
        end
        if (out_load)
        begin
            out_data_reg <= {5'b0, refused_next, enabled_next, owner_next, level_next};
        end
    end

    assign limit    = (half_period_reg == '0) ? 16'd1 : half_period_reg;
    assign tick_inc = 16'(tick_count_reg + 16'd1);

    always_comb
    begin
        owner_next        = owner_reg;
        half_period_next  = half_period_reg;
        tick_count_next   = tick_count_reg;
        toggles_left_next = toggles_left_reg;
        endless_next      = endless_reg;
        enabled_next      = enabled_reg;
        level_next        = level_reg;
        refused_next      = 1'b0;
        if (cmd.apply_now)
        begin
            case (op)
                sqtg_pkg::OP_TICK:
                begin
                    if (enabled_reg)
                    begin
                        if (tick_inc >= limit)
                        begin
                            tick_count_next = '0;
                            if (endless_reg || (toggles_left_reg != '0))
                            begin
                                level_next = !level_reg;
                                if (!endless_reg)
                                begin
                                    toggles_left_next = toggles_left_reg - 23'd1;
                                end
                            end
                            else
                            begin
                                enabled_next = 1'b0;
                                level_next   = 1'b0;
                            end
                        end
                        else
                        begin
                            tick_count_next = tick_inc;
                        end
                    end
                end
                sqtg_pkg::OP_PLAY:
                begin
                    refused_next = 1'b1;
                end
                sqtg_pkg::OP_STOP:
                begin
                    if (owner_reg == pin_in)
                    begin
                        owner_next   = sqtg_pkg::NO_OWNER;
                        enabled_next = 1'b0;
                        level_next   = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.commit)
        begin
            owner_next        = pin_reg;
            half_period_next  = half_tmp_reg;
            toggles_left_next = budget_reg;
            endless_next      = (dur_reg == '0);
            tick_count_next   = '0;
            enabled_next      = 1'b1;
        end
    end

    assign out_load = cmd.apply_now || cmd.commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_reg        <= sqtg_pkg::NO_OWNER;
            half_period_reg  <= '0;
            tick_count_reg   <= '0;
            toggles_left_reg <= '0;
            endless_reg      <= 1'b0;
            enabled_reg      <= 1'b0;
            level_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            owner_reg        <= owner_next;
            half_period_reg  <= half_period_next;
            tick_count_reg   <= tick_count_next;
            toggles_left_reg <= toggles_left_next;
            endless_reg      <= endless_next;
            enabled_reg      <= enabled_next;
            level_reg        <= level_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/sqtg_ctrl.sv =====
module sqtg_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [sqtg_pkg::OP_W-1:0] op,
    input  sqtg_pkg::status_t         status,
    output sqtg_pkg::cmd_t            cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_DIV1   = 3'd2;
    localparam logic [2:0] ST_LOAD2  = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [sqtg_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                          last_step;
    logic                          accept;

    assign in_ready  = (state_reg == ST_IDLE) && status.out_free;
    assign accept    = in_valid && in_ready;
    assign last_step = (step_reg == sqtg_pkg::STEP_W'(sqtg_pkg::DIV_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((op == sqtg_pkg::OP_PLAY) && !status.play_refused)
                    begin
                        cmd.start_play = 1'b1;
                        state_next     = ST_MUL;
                    end
                    else
                    begin
                        cmd.apply_now = 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul_load    = 1'b1;
                cmd.div_load_tb = 1'b1;
                step_next       = '0;
                state_next      = ST_DIV1;
            end
            ST_DIV1:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (last_step)
                begin
                    state_next = ST_LOAD2;
                end
            end
            ST_LOAD2:
            begin
                cmd.save_half   = 1'b1;
                cmd.budget_load = 1'b1;
                state_next      = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== design/square_wave_tone_generator_core.sv =====
// Tick, stop, unused and refused play transactions: result in the cycle after acceptance,
// one transaction per cycle while the result side keeps up.
// An accepted play blocks further transactions until its result: a product is registered, a
// one-bit-per-cycle divider runs 32 steps for the half period, one reciprocal multiply
// gives the budget, and the commit waits while the result side stalls.
// Reset is asynchronous and active low: generator free, pin low, all counters zero.
module square_wave_tone_generator_core #(
    parameter int unsigned TIMEBASE_HZ = sqtg_pkg::TIMEBASE_HZ_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // pin_number[7:0], frequency_hz[23:8], duration_ms[55:24]
    input  logic [sqtg_pkg::S_DATA_W-1:0] s_tdata,
    // op[1:0]
    input  logic [sqtg_pkg::OP_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pin_level[0], owner_pin[8:1], running[9], refused[10], zero[15:11]
    output logic [sqtg_pkg::M_DATA_W-1:0] m_tdata
);

    sqtg_pkg::cmd_t    cmd;
    sqtg_pkg::status_t status;

    sqtg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .op       (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    sqtg_datapath #(
        .TIMEBASE_HZ (TIMEBASE_HZ)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .op        (s_tuser),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
